// ----- src/hss_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hss_pkg: shared types and constants of the hydropathy segment scanner
// Holds the residue hydropathy table, the class codes, the register index
// codes and the configuration and result structures.
// ---------------------------------------------------------------------------
package hss_pkg;

	// register index codes on the configuration port
	typedef enum logic [2:0] {
		REG_MIN_LENGTH     = 3'd0,
		REG_MAX_LENGTH     = 3'd1,
		REG_MID_PERCENT    = 3'd2,
		REG_HIGH_PERCENT   = 3'd3,
		REG_LOW_THRESHOLD  = 3'd4,
		REG_MID_THRESHOLD  = 3'd5,
		REG_HIGH_THRESHOLD = 3'd6
	} hss_reg_idx_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned LEN_W      = 6;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned HYD_W      = 10;
	localparam int unsigned OUT_POS_W  = 11;
	localparam int unsigned SHARE_W    = LEN_W + PCT_W;

	// hydropathy classes
	typedef enum logic [1:0] {
		CLASS_HYDROPHILIC = 2'd0,
		CLASS_WEAK        = 2'd1,
		CLASS_MODERATE    = 2'd2,
		CLASS_STRONG      = 2'd3
	} hss_class_t;

	localparam logic [LEN_W-1:0]   RUN_SAT = 6'd63;
	localparam logic [SHARE_W-1:0] HUNDRED = 13'd100;

	// reset values of the configuration registers
	localparam logic [LEN_W-1:0] RST_MIN_LENGTH     = 6'd16;
	localparam logic [LEN_W-1:0] RST_MAX_LENGTH     = 6'd30;
	localparam logic [PCT_W-1:0] RST_MID_PERCENT    = 7'd50;
	localparam logic [PCT_W-1:0] RST_HIGH_PERCENT   = 7'd60;
	localparam logic [HYD_W-1:0] RST_LOW_THRESHOLD  = 10'd300;
	localparam logic [HYD_W-1:0] RST_MID_THRESHOLD  = 10'd501;
	localparam logic [HYD_W-1:0] RST_HIGH_THRESHOLD = 10'd750;

	typedef struct packed {
		logic [LEN_W-1:0] min_length;
		logic [LEN_W-1:0] max_length;
		logic [PCT_W-1:0] mid_percent;
		logic [PCT_W-1:0] high_percent;
		logic [HYD_W-1:0] low_threshold;
		logic [HYD_W-1:0] mid_threshold;
		logic [HYD_W-1:0] high_threshold;
	} hss_cfg_t;

	typedef struct packed {
		hss_class_t           hydropathy_class;
		logic                 segment_valid;
		logic                 segment_kind;
		logic [OUT_POS_W-1:0] segment_start;
		logic [OUT_POS_W-1:0] segment_end;
		logic [LEN_W-1:0]     segment_length;
		logic [LEN_W-1:0]     hydrophobic_count;
		logic                 none_found;
		logic                 end_of_sequence;
	} hss_result_t;

	// hydropathy value in thousandths of an uppercase one-letter code
	function automatic logic [HYD_W-1:0] hydro_value(input logic [7:0] c);
		logic [HYD_W-1:0] v;
		unique case (c)
			8'h41: v = 10'd616;  // A
			8'h43: v = 10'd680;  // C
			8'h44: v = 10'd28;   // D
			8'h45: v = 10'd43;   // E
			8'h46: v = 10'd1000; // F
			8'h47: v = 10'd501;  // G
			8'h48: v = 10'd165;  // H
			8'h49: v = 10'd943;  // I
			8'h4B: v = 10'd283;  // K
			8'h4C: v = 10'd943;  // L
			8'h4D: v = 10'd738;  // M
			8'h4E: v = 10'd236;  // N
			8'h50: v = 10'd711;  // P
			8'h51: v = 10'd251;  // Q
			8'h53: v = 10'd359;  // S
			8'h54: v = 10'd450;  // T
			8'h56: v = 10'd825;  // V
			8'h57: v = 10'd878;  // W
			8'h59: v = 10'd880;  // Y
			default: v = '0;     // R and unknown letters
		endcase
		return v;
	endfunction

endpackage

// ----- src/hydropathy_segment_scanner_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hydropathy_segment_scanner_core: streaming transmembrane segment scanner
// Grades each residue of a sequence by hydropathy, tracks runs of
// non-hydrophilic residues and reports qualifying segments.
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  in       | in_valid / in_stall (out)  | residue, last_residue
//  out      | out_valid / out_stall (in) | hydropathy_class ... end_of_sequence
//  cfg      | cfg_wr_en                  | cfg_index, cfg_wr_data
//
//  one residue per cycle sustained while the output is not stalled; each result
//  passes the input register, then the result register
//  the run state moves on as a residue passes from the input register into
//  the result register, so consecutive residues follow without a gap
//  reset clears the run state, the handshake flags and sets the registers
//  to their defaults; a held result stalls the input register, and the input
//  is stalled only when both registers are full
// ---------------------------------------------------------------------------
module hydropathy_segment_scanner_core
	import hss_pkg::*;
#(
	parameter int unsigned MAX_RESIDUES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            residue,
	input  logic                  last_residue,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            hydropathy_class,
	output logic                  segment_valid,
	output logic                  segment_kind,
	output logic [OUT_POS_W-1:0]  segment_start,
	output logic [OUT_POS_W-1:0]  segment_end,
	output logic [LEN_W-1:0]      segment_length,
	output logic [LEN_W-1:0]      hydrophobic_count,
	output logic                  none_found,
	output logic                  end_of_sequence,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

	hss_cfg_t    cfg_q;
	logic        valid_s1;
	logic [7:0]  residue_s1;
	logic        last_s1;
	logic        out_valid_q;
	hss_result_t result_q;
	hss_result_t result;
	hss_class_t  cls;
	logic        advance;
	logic        in_take;

	// handshake: input register drains into the result register
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length     <= RST_MIN_LENGTH;
			cfg_q.max_length     <= RST_MAX_LENGTH;
			cfg_q.mid_percent    <= RST_MID_PERCENT;
			cfg_q.high_percent   <= RST_HIGH_PERCENT;
			cfg_q.low_threshold  <= RST_LOW_THRESHOLD;
			cfg_q.mid_threshold  <= RST_MID_THRESHOLD;
			cfg_q.high_threshold <= RST_HIGH_THRESHOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MIN_LENGTH:     cfg_q.min_length     <= cfg_wr_data[LEN_W-1:0];
				REG_MAX_LENGTH:     cfg_q.max_length     <= cfg_wr_data[LEN_W-1:0];
				REG_MID_PERCENT:    cfg_q.mid_percent    <= cfg_wr_data[PCT_W-1:0];
				REG_HIGH_PERCENT:   cfg_q.high_percent   <= cfg_wr_data[PCT_W-1:0];
				REG_LOW_THRESHOLD:  cfg_q.low_threshold  <= cfg_wr_data[HYD_W-1:0];
				REG_MID_THRESHOLD:  cfg_q.mid_threshold  <= cfg_wr_data[HYD_W-1:0];
				REG_HIGH_THRESHOLD: cfg_q.high_threshold <= cfg_wr_data[HYD_W-1:0];
				default: ;
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			residue_s1 <= residue;
			last_s1    <= last_residue;
		end
	end

	hss_classifier u_classifier (
		.residue          (residue_s1),
		.cfg              (cfg_q),
		.hydropathy_class (cls)
	);

	hss_segment_tracker #(
		.MAX_RESIDUES (MAX_RESIDUES)
	) u_tracker (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.last_residue     (last_s1),
		.hydropathy_class (cls),
		.cfg              (cfg_q),
		.result           (result)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid         = out_valid_q;
	assign hydropathy_class  = result_q.hydropathy_class;
	assign segment_valid     = result_q.segment_valid;
	assign segment_kind      = result_q.segment_kind;
	assign segment_start     = result_q.segment_start;
	assign segment_end       = result_q.segment_end;
	assign segment_length    = result_q.segment_length;
	assign hydrophobic_count = result_q.hydrophobic_count;
	assign none_found        = result_q.none_found;
	assign end_of_sequence   = result_q.end_of_sequence;

endmodule

// ----- src/hss_classifier.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hss_classifier: residue grading
// Looks a residue letter up as a hydropathy value and grades it into one of
// four classes against the three threshold registers.
// ---------------------------------------------------------------------------
module hss_classifier
	import hss_pkg::*;
(
	input  logic [7:0] residue,
	input  hss_cfg_t   cfg,
	output hss_class_t hydropathy_class
);

	logic [HYD_W-1:0] value;

	// table lookup
	assign value = hydro_value(residue);

	// threshold chain, first match wins
	always_comb begin
		priority if (value <= cfg.low_threshold) begin
			hydropathy_class = CLASS_HYDROPHILIC;
		end else if (value <= cfg.mid_threshold) begin
			hydropathy_class = CLASS_WEAK;
		end else if (value <= cfg.high_threshold) begin
			hydropathy_class = CLASS_MODERATE;
		end else begin
			hydropathy_class = CLASS_STRONG;
		end
	end

endmodule

// ----- src/hss_segment_tracker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hss_segment_tracker: run tracking and segment decision
// Holds the per-sequence run state, closes a run at a hydrophilic residue or
// at the sequence end, tests its length and hydrophobic share and builds the
// result of one residue. State moves on when step is high.
// ---------------------------------------------------------------------------
module hss_segment_tracker
	import hss_pkg::*;
#(
	parameter int unsigned MAX_RESIDUES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        last_residue,
	input  hss_class_t  hydropathy_class,
	input  hss_cfg_t    cfg,
	output hss_result_t result
);

	localparam int unsigned POS_W = $clog2(MAX_RESIDUES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_RESIDUES);

	logic             in_segment_q;
	logic [POS_W-1:0] position_q;
	logic [POS_W-1:0] run_start_q;
	logic [LEN_W-1:0] run_length_q;
	logic [LEN_W-1:0] run_hydrophobic_q;
	logic             any_found_q;

	logic             is_run;
	logic             is_hydrophobic;
	logic [POS_W-1:0] pos_n;
	logic [POS_W-1:0] start_n;
	logic [LEN_W-1:0] len_base;
	logic [LEN_W-1:0] hyd_base;
	logic [LEN_W-1:0] len_n;
	logic [LEN_W-1:0] hyd_n;
	logic             ended;
	logic [POS_W-1:0] end_pos;
	logic             len_ok;
	logic [SHARE_W-1:0] share;
	logic [SHARE_W-1:0] mid_prod;
	logic [SHARE_W-1:0] high_prod;
	logic             ge_mid;
	logic             ge_high;
	logic             hit;
	logic             any_n;
	logic [POS_W+OUT_POS_W-1:0] start_ext;
	logic [POS_W+OUT_POS_W-1:0] end_ext;

	assign is_run         = (hydropathy_class != CLASS_HYDROPHILIC);
	assign is_hydrophobic = hydropathy_class[1];

	// saturating position
	assign pos_n = (position_q < POS_MAX) ? position_q + 1'b1 : POS_MAX;

	// run counters, a fresh run starts at this residue
	always_comb begin
		if (is_run && !in_segment_q) begin
			start_n  = pos_n;
			len_base = '0;
			hyd_base = '0;
		end else begin
			start_n  = run_start_q;
			len_base = run_length_q;
			hyd_base = run_hydrophobic_q;
		end
		len_n = len_base;
		hyd_n = hyd_base;
		if (is_run) begin
			if (len_base < RUN_SAT) begin
				len_n = len_base + 1'b1;
			end
			if (is_hydrophobic && hyd_base < RUN_SAT) begin
				hyd_n = hyd_base + 1'b1;
			end
		end
	end

	// run end: hydrophilic residue closes before it, last residue closes on it
	assign ended   = is_run ? last_residue : in_segment_q;
	assign end_pos = is_run ? pos_n : position_q;

	// length window and exact share test by cross-multiplication
	assign len_ok    = (len_n != RUN_SAT) && (len_n >= cfg.min_length)
		&& (len_n <= cfg.max_length);
	assign share     = SHARE_W'(hyd_n) * HUNDRED;
	assign mid_prod  = SHARE_W'(cfg.mid_percent) * SHARE_W'(len_n);
	assign high_prod = SHARE_W'(cfg.high_percent) * SHARE_W'(len_n);
	assign ge_mid    = (share >= mid_prod);
	assign ge_high   = (share >= high_prod);
	assign hit       = ended && len_ok && (ge_mid || ge_high);
	assign any_n     = any_found_q || hit;

	assign start_ext = {{OUT_POS_W{1'b0}}, start_n};
	assign end_ext   = {{OUT_POS_W{1'b0}}, end_pos};

	// result of this residue
	always_comb begin
		result                   = '0;
		result.hydropathy_class  = hydropathy_class;
		result.end_of_sequence   = last_residue;
		result.none_found        = last_residue && !any_n;
		if (hit) begin
			result.segment_valid     = 1'b1;
			result.segment_kind      = ge_high;
			result.segment_start     = start_ext[OUT_POS_W-1:0];
			result.segment_end       = end_ext[OUT_POS_W-1:0];
			result.segment_length    = len_n;
			result.hydrophobic_count = hyd_n;
		end
	end

	// run state, cleared at the sequence end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_segment_q      <= 1'b0;
			position_q        <= '0;
			run_start_q       <= '0;
			run_length_q      <= '0;
			run_hydrophobic_q <= '0;
			any_found_q       <= 1'b0;
		end else if (step) begin
			if (last_residue) begin
				in_segment_q      <= 1'b0;
				position_q        <= '0;
				run_start_q       <= '0;
				run_length_q      <= '0;
				run_hydrophobic_q <= '0;
				any_found_q       <= 1'b0;
			end else begin
				in_segment_q      <= is_run;
				position_q        <= pos_n;
				run_start_q       <= start_n;
				run_length_q      <= len_n;
				run_hydrophobic_q <= hyd_n;
				any_found_q       <= any_n;
			end
		end
	end

endmodule

// ----- tb/hydropathy_segment_scanner_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hydropathy_segment_scanner_core_test: self-checking bench of the scanner
// Walks a short table of residues and register writes, then streams random
// sequences under many register settings with random idling on both sides.
// Every result transfer is compared with an in-bench scan of the stream or with a typed row's expected result.
// ---------------------------------------------------------------------------
module hydropathy_segment_scanner_core_test;
	import hss_pkg::*;

	localparam int unsigned SEQ_CAP        = 1024;
	localparam int unsigned RANDOM_ITEMS   = 520;
	localparam int unsigned CALM_TAIL      = 200;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned WATCHDOG_LIMIT = 500;

	typedef enum logic {ROW_RESIDUE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [7:0]           code;
		logic                 last;
		bit                   typed;
		hss_result_t          golden;
		hss_reg_idx_t         reg_idx;
		logic [CFG_DATA_W-1:0] value;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [7:0]            residue      = '0;
	logic                  last_residue = 1'b0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [1:0]            hydropathy_class;
	logic                  segment_valid;
	logic                  segment_kind;
	logic [OUT_POS_W-1:0]  segment_start;
	logic [OUT_POS_W-1:0]  segment_end;
	logic [LEN_W-1:0]      segment_length;
	logic [LEN_W-1:0]      hydrophobic_count;
	logic                  none_found;
	logic                  end_of_sequence;
	logic                  cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

	// typed expectation travelling with the residue it belongs to
	bit                    typed_ok     = 1'b0;
	hss_result_t           typed_res    = '0;

	// scan model state and register copy
	hss_cfg_t              cfg_model;
	logic                  track_open;
	logic [OUT_POS_W-1:0]  track_pos;
	logic [OUT_POS_W-1:0]  track_start;
	logic [LEN_W-1:0]      track_len;
	logic [LEN_W-1:0]      track_oily;
	logic                  seq_hit;

	hss_result_t           awaited[$];
	int unsigned           mismatches    = 0;
	int unsigned           checked       = 0;
	int unsigned           segments_seen = 0;
	int unsigned           items_sent    = 0;
	int unsigned           seqs_sent     = 0;
	int unsigned           settings_used = 1;
	int unsigned           quiet_cycles  = 0;
	int unsigned           send_odds     = 0;
	int unsigned           stall_odds    = 0;

	hydropathy_segment_scanner_core #(
		.MAX_RESIDUES(SEQ_CAP)
	) i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.residue           (residue),
		.last_residue      (last_residue),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.hydropathy_class  (hydropathy_class),
		.segment_valid     (segment_valid),
		.segment_kind      (segment_kind),
		.segment_start     (segment_start),
		.segment_end       (segment_end),
		.segment_length    (segment_length),
		.hydrophobic_count (hydrophobic_count),
		.none_found        (none_found),
		.end_of_sequence   (end_of_sequence),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_wr_data       (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hydropathy in thousandths; anything not in the list counts as zero
	function automatic int unsigned residue_milli(input logic [7:0] code);
		case (code)
			"A": return 616;
			"C": return 680;
			"D": return 28;
			"E": return 43;
			"F": return 1000;
			"G": return 501;
			"H": return 165;
			"I": return 943;
			"K": return 283;
			"L": return 943;
			"M": return 738;
			"N": return 236;
			"P": return 711;
			"Q": return 251;
			"S": return 359;
			"T": return 450;
			"V": return 825;
			"W": return 878;
			"Y": return 880;
			default: return 0;
		endcase
	endfunction

	// threshold chain, taken in order whatever the register values
	function automatic hss_class_t grade(input int unsigned v);
		if (v <= cfg_model.low_threshold) return CLASS_HYDROPHILIC;
		if (v <= cfg_model.mid_threshold) return CLASS_WEAK;
		if (v <= cfg_model.high_threshold) return CLASS_MODERATE;
		return CLASS_STRONG;
	endfunction

	function automatic void clear_track();
		track_open  = 1'b0;
		track_pos   = '0;
		track_start = '0;
		track_len   = '0;
		track_oily  = '0;
		seq_hit     = 1'b0;
	endfunction

	// advance the scan by one residue and return the result it causes
	function automatic hss_result_t scan_residue(input logic [7:0] code, input logic last);
		hss_result_t          r;
		hss_class_t           cls;
		logic [OUT_POS_W-1:0] prev_pos;
		logic [OUT_POS_W-1:0] stop_pos;
		logic                 closes;
		int unsigned          share;
		int unsigned          mid_bar;
		int unsigned          high_bar;
		r        = '0;
		cls      = grade(residue_milli(code));
		prev_pos = track_pos;
		stop_pos = '0;
		closes   = 1'b0;
		if (track_pos < SEQ_CAP)
			track_pos = track_pos + 1'b1;

		// run bookkeeping: open, count, or close on a hydrophilic or final residue
		if (cls != CLASS_HYDROPHILIC) begin
			if (!track_open) begin
				track_open  = 1'b1;
				track_start = track_pos;
				track_len   = '0;
				track_oily  = '0;
			end
			if (track_len != RUN_SAT)
				track_len = track_len + 1'b1;
			if (cls >= CLASS_MODERATE && track_oily != RUN_SAT)
				track_oily = track_oily + 1'b1;
			if (last) begin
				closes   = 1'b1;
				stop_pos = track_pos;
			end
		end else if (track_open) begin
			closes   = 1'b1;
			stop_pos = prev_pos;
		end

		// length window, then exact share test against both percents
		if (closes) begin
			if (track_len != RUN_SAT && track_len >= cfg_model.min_length &&
					track_len <= cfg_model.max_length) begin
				share    = track_oily * 100;
				mid_bar  = cfg_model.mid_percent * track_len;
				high_bar = cfg_model.high_percent * track_len;
				if (share >= mid_bar || share >= high_bar) begin
					r.segment_valid     = 1'b1;
					r.segment_kind      = (share >= high_bar);
					r.segment_start     = track_start;
					r.segment_end       = stop_pos;
					r.segment_length    = track_len;
					r.hydrophobic_count = track_oily;
					seq_hit             = 1'b1;
				end
			end
			track_open = 1'b0;
		end

		r.hydropathy_class = cls;
		r.end_of_sequence  = last;
		if (last) begin
			r.none_found = !seq_hit;
			clear_track();
		end
		return r;
	endfunction

	function automatic string show(input hss_result_t r);
		return $sformatf("cls=%0d seg=%0d kind=%0d start=%0d end=%0d len=%0d hyd=%0d none=%0d eos=%0d",
			r.hydropathy_class, r.segment_valid, r.segment_kind, r.segment_start,
			r.segment_end, r.segment_length, r.hydrophobic_count, r.none_found,
			r.end_of_sequence);
	endfunction

	// scoreboard: register writes, input transfers, result transfers, watchdog
	always @(posedge clk) begin : scoreboard
		hss_result_t want;
		hss_result_t got;
		if (!arst_n) begin
			cfg_model.min_length     = RST_MIN_LENGTH;
			cfg_model.max_length     = RST_MAX_LENGTH;
			cfg_model.mid_percent    = RST_MID_PERCENT;
			cfg_model.high_percent   = RST_HIGH_PERCENT;
			cfg_model.low_threshold  = RST_LOW_THRESHOLD;
			cfg_model.mid_threshold  = RST_MID_THRESHOLD;
			cfg_model.high_threshold = RST_HIGH_THRESHOLD;
			clear_track();
			quiet_cycles = 0;
		end else begin
			if (cfg_wr_en) begin
				case (hss_reg_idx_t'(cfg_index))
					REG_MIN_LENGTH:     cfg_model.min_length     = cfg_wr_data[LEN_W-1:0];
					REG_MAX_LENGTH:     cfg_model.max_length     = cfg_wr_data[LEN_W-1:0];
					REG_MID_PERCENT:    cfg_model.mid_percent    = cfg_wr_data[PCT_W-1:0];
					REG_HIGH_PERCENT:   cfg_model.high_percent   = cfg_wr_data[PCT_W-1:0];
					REG_LOW_THRESHOLD:  cfg_model.low_threshold  = cfg_wr_data[HYD_W-1:0];
					REG_MID_THRESHOLD:  cfg_model.mid_threshold  = cfg_wr_data[HYD_W-1:0];
					REG_HIGH_THRESHOLD: cfg_model.high_threshold = cfg_wr_data[HYD_W-1:0];
					default: ;
				endcase
			end

			// input transfer: the model moves on, typed rows override its answer
			if (in_valid && !in_stall) begin
				want = scan_residue(residue, last_residue);
				if (typed_ok)
					want = typed_res;
				awaited.push_back(want);
			end

			// result transfer: compare with the oldest expectation
			if (out_valid && !out_stall) begin
				got.hydropathy_class  = hss_class_t'(hydropathy_class);
				got.segment_valid     = segment_valid;
				got.segment_kind      = segment_kind;
				got.segment_start     = segment_start;
				got.segment_end       = segment_end;
				got.segment_length    = segment_length;
				got.hydrophobic_count = hydrophobic_count;
				got.none_found        = none_found;
				got.end_of_sequence   = end_of_sequence;
				if (awaited.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected result: %s", $realtime, show(got));
				end else begin
					want = awaited.pop_front();
					checked++;
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("[%0t] result %0d differs", $realtime, checked);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end else if (got.segment_valid) begin
						segments_seen++;
					end
				end
			end

			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					quiet_cycles, awaited.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, none while stall_odds is zero
	initial begin : receiver
		int unsigned burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (stall_odds == 0) begin
				out_stall <= 1'b0;
				burst = 0;
			end else if (burst > 0) begin
				burst--;
			end else if ($urandom_range(stall_odds - 1, 0) == 0) begin
				out_stall <= 1'b1;
				burst = $urandom_range(15, 1) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_residue(input logic [7:0] code, input logic last, input bit typed,
			input hss_result_t golden);
		if (send_odds != 0 && $urandom_range(send_odds - 1, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		residue      <= code;
		last_residue <= last;
		typed_ok     <= typed;
		typed_res    <= golden;
		do @(posedge clk); while (!(in_valid && !in_stall));
		items_sent++;
	endtask

	task automatic write_reg(input hss_reg_idx_t idx, input int unsigned value);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
	endtask

	// hold the sender until every result is back and the pipeline is empty
	task automatic drain_scanner();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] oily_letter();
		string set;
		set = "ACFGILMPVWYT";
		return set[$urandom_range(set.len() - 1, 0)];
	endfunction

	function automatic logic [7:0] wet_letter();
		string set;
		set = "DEHKNQRS";
		return set[$urandom_range(set.len() - 1, 0)];
	endfunction

	// one sequence: mostly hydrophilic gaps and oily runs, some noise
	task automatic send_sequence();
		logic [7:0]  seq[$];
		int unsigned style;
		int unsigned n;
		style = $urandom_range(9, 0);
		if (style == 0) begin
			repeat ($urandom_range(24, 1)) seq.push_back(8'($urandom_range(255, 0)));
		end else begin
			repeat ($urandom_range(4, 1)) begin
				repeat ($urandom_range(6, 0)) seq.push_back(wet_letter());
				n = ($urandom_range(9, 0) == 0) ? $urandom_range(75, 36) : $urandom_range(35, 1);
				repeat (n)
					seq.push_back(($urandom_range(11, 0) == 0) ? wet_letter() : oily_letter());
			end
			// broken sequence: letters replaced by arbitrary bytes
			if (style == 1)
				foreach (seq[i])
					if ($urandom_range(4, 0) == 0)
						seq[i] = 8'($urandom_range(255, 0));
			if ($urandom_range(1, 0) == 1)
				seq.push_back(wet_letter());
		end
		foreach (seq[i])
			push_residue(seq[i], i == seq.size() - 1, 1'b0, '0);
		seqs_sent++;
	endtask

	function automatic stim_row_t residue_row(input logic [7:0] code, input logic last);
		stim_row_t r;
		r = '{kind: ROW_RESIDUE, code: code, last: last, typed: 1'b0, golden: '0,
			reg_idx: REG_MIN_LENGTH, value: '0};
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [7:0] code, input logic last,
			input hss_class_t cls, input int unsigned seg, input int unsigned kind,
			input int unsigned start, input int unsigned stop, input int unsigned len,
			input int unsigned hyd, input int unsigned none);
		stim_row_t r;
		r = residue_row(code, last);
		r.typed                    = 1'b1;
		r.golden.hydropathy_class  = cls;
		r.golden.segment_valid     = (seg != 0);
		r.golden.segment_kind      = (kind != 0);
		r.golden.segment_start     = OUT_POS_W'(start);
		r.golden.segment_end       = OUT_POS_W'(stop);
		r.golden.segment_length    = LEN_W'(len);
		r.golden.hydrophobic_count = LEN_W'(hyd);
		r.golden.none_found        = (none != 0);
		r.golden.end_of_sequence   = last;
		return r;
	endfunction

	function automatic stim_row_t write_row(input hss_reg_idx_t idx, input int unsigned value);
		stim_row_t r;
		r = residue_row('0, 1'b0);
		r.kind    = ROW_WRITE;
		r.reg_idx = idx;
		r.value   = value[CFG_DATA_W-1:0];
		return r;
	endfunction

	initial begin : stimulus
		stim_row_t   rows[$];
		logic [7:0]  long_seq[$];
		int unsigned base;
		int unsigned pick;
		int unsigned lo_len;
		int unsigned hi_len;
		int unsigned lo_pct;
		int unsigned hi_pct;
		int unsigned swap;
		int unsigned t0;
		int unsigned t1;
		int unsigned t2;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: class boundaries, unknown codes, short runs
		rows.push_back(typed_row("F", 1'b0, CLASS_STRONG, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(typed_row("R", 1'b0, CLASS_HYDROPHILIC, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(typed_row(8'h00, 1'b1, CLASS_HYDROPHILIC, 0, 0, 0, 0, 0, 0, 1));
		rows.push_back(typed_row(8'hFF, 1'b0, CLASS_HYDROPHILIC, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(typed_row("G", 1'b0, CLASS_WEAK, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(typed_row("K", 1'b0, CLASS_HYDROPHILIC, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(typed_row("S", 1'b0, CLASS_WEAK, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(typed_row("M", 1'b0, CLASS_MODERATE, 0, 0, 0, 0, 0, 0, 0));
		rows.push_back(typed_row("V", 1'b1, CLASS_STRONG, 0, 0, 0, 0, 0, 0, 1));
		// widest length window, percent extremes: a one-residue trailing run
		rows.push_back(write_row(REG_MIN_LENGTH, 1));
		rows.push_back(write_row(REG_MAX_LENGTH, 62));
		rows.push_back(write_row(REG_MID_PERCENT, 0));
		rows.push_back(write_row(REG_HIGH_PERCENT, 100));
		rows.push_back(typed_row("F", 1'b1, CLASS_STRONG, 1, 1, 1, 1, 1, 1, 0));
		// every letter above zero is weak, run of weak letters at zero share
		rows.push_back(write_row(REG_LOW_THRESHOLD, 0));
		rows.push_back(write_row(REG_MID_THRESHOLD, 1000));
		rows.push_back(write_row(REG_HIGH_THRESHOLD, 1000));
		rows.push_back(residue_row("D", 1'b0));
		rows.push_back(residue_row("E", 1'b0));
		rows.push_back(residue_row("H", 1'b0));
		rows.push_back(residue_row("N", 1'b0));
		rows.push_back(residue_row("Q", 1'b0));
		rows.push_back(residue_row("T", 1'b1));
		// everything hydrophilic
		rows.push_back(write_row(REG_LOW_THRESHOLD, 1000));
		rows.push_back(write_row(REG_MID_THRESHOLD, 0));
		rows.push_back(write_row(REG_HIGH_THRESHOLD, 0));
		rows.push_back(residue_row("C", 1'b0));
		rows.push_back(residue_row("W", 1'b1));
		// unordered thresholds and percents, run closed by the final residue
		rows.push_back(write_row(REG_LOW_THRESHOLD, 300));
		rows.push_back(write_row(REG_MID_THRESHOLD, 100));
		rows.push_back(write_row(REG_HIGH_THRESHOLD, 900));
		rows.push_back(write_row(REG_MID_PERCENT, 100));
		rows.push_back(write_row(REG_HIGH_PERCENT, 0));
		rows.push_back(write_row(REG_MIN_LENGTH, 3));
		rows.push_back(write_row(REG_MAX_LENGTH, 4));
		rows.push_back(residue_row("A", 1'b0));
		rows.push_back(residue_row("I", 1'b0));
		rows.push_back(residue_row("L", 1'b0));
		rows.push_back(residue_row("P", 1'b0));
		rows.push_back(residue_row("R", 1'b1));
		// reversed length bounds
		rows.push_back(write_row(REG_MIN_LENGTH, 2));
		rows.push_back(write_row(REG_MAX_LENGTH, 1));
		rows.push_back(residue_row("A", 1'b0));
		rows.push_back(residue_row("A", 1'b0));
		rows.push_back(residue_row("R", 1'b1));

		send_odds  = 4;
		stall_odds = 5;
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_WRITE) begin
				if (i > 0 && rows[i - 1].kind == ROW_RESIDUE)
					drain_scanner();
				write_reg(rows[i].reg_idx, rows[i].value);
			end else begin
				push_residue(rows[i].code, rows[i].last, rows[i].typed, rows[i].golden);
			end
		end

		// long sequence at reset registers: saturated run, then position cap
		drain_scanner();
		write_reg(REG_MIN_LENGTH, int'(RST_MIN_LENGTH));
		write_reg(REG_MAX_LENGTH, int'(RST_MAX_LENGTH));
		write_reg(REG_MID_PERCENT, int'(RST_MID_PERCENT));
		write_reg(REG_HIGH_PERCENT, int'(RST_HIGH_PERCENT));
		write_reg(REG_LOW_THRESHOLD, int'(RST_LOW_THRESHOLD));
		write_reg(REG_MID_THRESHOLD, int'(RST_MID_THRESHOLD));
		write_reg(REG_HIGH_THRESHOLD, int'(RST_HIGH_THRESHOLD));
		settings_used++;
		repeat (70) long_seq.push_back("L");
		long_seq.push_back("D");
		while (long_seq.size() < SEQ_CAP - 19)
			long_seq.push_back(($urandom_range(2, 0) == 0) ? wet_letter() : oily_letter());
		long_seq.push_back("D");
		repeat (25) long_seq.push_back("L");
		foreach (long_seq[i])
			push_residue(long_seq[i], i == long_seq.size() - 1, 1'b0, '0);
		seqs_sent++;

		// random phases, each under fresh register values; the run closes on a
		// phase without idling
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS || send_odds != 0 || stall_odds != 0) begin
			drain_scanner();
			pick   = $urandom_range(7, 0);
			lo_len = $urandom_range(20, 1);
			hi_len = $urandom_range(62, lo_len);
			lo_pct = $urandom_range(80, 0);
			hi_pct = $urandom_range(100, lo_pct);
			t0     = $urandom_range(700, 0);
			t1     = $urandom_range(900, t0);
			t2     = $urandom_range(1000, t1);
			case (pick)
				0: begin
					lo_len = 1;
					hi_len = 62;
					t0     = 0;
					t1     = 500;
					t2     = 1000;
				end
				1: begin
					lo_len = 62;
					hi_len = 62;
					lo_pct = 100;
					hi_pct = 100;
				end
				2: if (lo_len > 1) hi_len = $urandom_range(lo_len - 1, 1);
				3: hi_len = lo_len;
				4: begin
					lo_pct = 0;
					hi_pct = 100;
				end
				5: begin
					swap   = lo_pct;
					lo_pct = hi_pct;
					hi_pct = swap;
				end
				6: begin
					t0 = $urandom_range(1000, 0);
					t1 = $urandom_range(1000, 0);
					t2 = $urandom_range(1000, 0);
				end
				default: begin
					t0 = int'(RST_LOW_THRESHOLD);
					t1 = int'(RST_MID_THRESHOLD);
					t2 = int'(RST_HIGH_THRESHOLD);
				end
			endcase
			write_reg(REG_MIN_LENGTH, lo_len);
			write_reg(REG_MAX_LENGTH, hi_len);
			write_reg(REG_MID_PERCENT, lo_pct);
			write_reg(REG_HIGH_PERCENT, hi_pct);
			write_reg(REG_LOW_THRESHOLD, t0);
			write_reg(REG_MID_THRESHOLD, t1);
			write_reg(REG_HIGH_THRESHOLD, t2);
			settings_used++;

			// no idling at all towards the end of the run
			if (items_sent - base > RANDOM_ITEMS - CALM_TAIL) begin
				send_odds  = 0;
				stall_odds = 0;
			end else begin
				case ($urandom_range(3, 0))
					0: send_odds = 0;
					1: send_odds = 2;
					2: send_odds = 4;
					default: send_odds = 10;
				endcase
				case ($urandom_range(3, 0))
					0: stall_odds = 0;
					1: stall_odds = 3;
					2: stall_odds = 6;
					default: stall_odds = 15;
				endcase
			end
			repeat ($urandom_range(5, 2)) send_sequence();
		end

		drain_scanner();
		repeat (8) @(posedge clk);
		mismatches += awaited.size();
		$display("covered %0d residues in %0d sequences over %0d register settings",
			items_sent, seqs_sent, settings_used);
		$display("checked %0d results, %0d segments reported, %0d mismatches",
			checked, segments_seen, mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
